// ===== rtl/core/uniform_lbp_pixel_stream_unit_macros.svh =====
// Assertion macros for the uniform LBP pixel stream unit.
`ifndef UNIFORM_LBP_PIXEL_STREAM_UNIT_MACROS_SVH
`define UNIFORM_LBP_PIXEL_STREAM_UNIT_MACROS_SVH

// Same-cycle implication.
`define ULBP_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ulbp assertion failed");

// Next-cycle implication.
`define ULBP_ASSERT_NXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ulbp assertion failed");

`endif

// ===== rtl/core/ulbp_pkg.sv =====
package ulbp_pkg;

  localparam int unsigned MaxWidthDef = 1024;
  localparam int unsigned MaxHeight   = 4096;
  localparam int unsigned PixW        = 8;
  localparam int unsigned LabelW      = 6;
  localparam int unsigned RowW        = 12;
  localparam int unsigned ColW        = 10;
  localparam int unsigned CfgIdxW     = 1;
  localparam int unsigned CfgDataW    = 13;
  localparam int unsigned WidthRegW   = 11;
  localparam int unsigned HeightRegW  = 13;
  localparam int unsigned SizeW       = 13;
  localparam int unsigned JobDepth    = 4;
  localparam int unsigned JobPtrW     = 2;
  localparam int unsigned JobCntW     = 3;
  localparam int unsigned WidthReset  = 160;
  localparam int unsigned HeightReset = 80;
  localparam int unsigned LabelMax    = 58;
  localparam int unsigned NumSlots    = 4;

  typedef enum logic [CfgIdxW-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef logic [PixW-1:0]   pix_t;
  typedef pix_t [8:0]        win_t;   // column k: [3k] top, [3k+1] mid, [3k+2] bottom
  typedef pix_t [2:0]        col_t;   // [0] top, [1] mid, [2] bottom
  typedef logic [LabelW-1:0] label_t;
  typedef label_t [255:0]    lut_t;

  // slot 0: upper row, col c-1; slot 1: upper row, col c (row end);
  // slot 2: last row, col c-1;  slot 3: last row, col c (frame end)
  typedef struct packed {
    win_t                win;
    logic [RowW-1:0]     row;
    logic [ColW-1:0]     col;
    logic                r_is0;
    logic                r_is1;
    logic                c_is0;
    logic                c_is1;
    logic [NumSlots-1:0] mask;
  } job_t;

  function automatic lut_t build_lut();
    lut_t       tab;
    int         nxt;
    logic [7:0] cd;
    logic [7:0] rot;
    nxt = 0;
    for (int i = 0; i < 256; i++) begin
      cd  = 8'(i);
      rot = {cd[6:0], cd[7]};
      if ($countones(cd ^ rot) <= 2) begin
        nxt    = nxt + 1;
        tab[i] = LabelW'(nxt);
      end else begin
        tab[i] = '0;
      end
    end
    return tab;
  endfunction

  localparam lut_t LbpLut = build_lut();

  function automatic label_t lbp_label(col_t lc, col_t cc, col_t rc);
    logic [7:0] code;
    pix_t       ctr;
    ctr     = cc[1];
    code[7] = (lc[0] >= ctr);
    code[6] = (lc[1] >= ctr);
    code[5] = (lc[2] >= ctr);
    code[4] = (cc[2] >= ctr);
    code[3] = (rc[2] >= ctr);
    code[2] = (rc[1] >= ctr);
    code[1] = (rc[0] >= ctr);
    code[0] = (cc[0] >= ctr);
    return LbpLut[code];
  endfunction

endpackage

// ===== rtl/core/ulbp_if.sv =====
interface ulbp_pixel_if import ulbp_pkg::*; ();
  logic valid;
  logic ready;
  pix_t pixel;
  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface ulbp_label_if import ulbp_pkg::*; ();
  logic            valid;
  logic            ready;
  label_t          label;
  logic [RowW-1:0] out_row;
  logic [ColW-1:0] out_col;
  logic            frame_end;
  modport source (output valid, output label, output out_row, output out_col,
                  output frame_end, input ready);
  modport sink   (input valid, input label, input out_row, input out_col,
                  input frame_end, output ready);
endinterface

interface ulbp_cfg_if import ulbp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/ulbp_jobq.sv =====
module ulbp_jobq import ulbp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  job_t               job_i,
  input  logic               pop_i,
  output job_t               head_o,
  output logic [JobCntW-1:0] count_o
);

  job_t               q_mem [JobDepth];
  logic [JobPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [JobPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [JobCntW-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + JobPtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + JobPtrW'(1) : rd_ptr_q;
    count_d  = count_q + JobCntW'(push_i) - JobCntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      q_mem[wr_ptr_q] <= job_i;
    end
  end

  assign head_o  = q_mem[rd_ptr_q];
  assign count_o = count_q;

endmodule

// ===== rtl/core/ulbp_front.sv =====
module ulbp_front import ulbp_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MaxWidthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  ulbp_pixel_if.sink         pixel_i,
  ulbp_cfg_if.sink           cfg_i,
  input  logic [JobCntW-1:0] q_count_i,
  output logic               push_o,
  output job_t               job_o
);

  localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic [WidthRegW-1:0]  width_q;
  logic [HeightRegW-1:0] height_q;
  logic [CW-1:0]         col_q;
  logic [RowW-1:0]       row_q;

  logic [SizeW-1:0] w_eff, h_eff;
  logic [CW-1:0]    wlast, c_cur;
  logic [RowW-1:0]  hlast, r_cur;
  logic             end_cur, last_cur, acc;

  logic              a_valid_q;
  pix_t              pix_a_q;
  logic [CW-1:0]     c_a_q;
  logic [RowW-1:0]   r_a_q;
  logic              end_a_q, last_a_q;
  logic [2*PixW-1:0] rd_q;
  logic [2*PixW-1:0] wr_data;

  logic [2*PixW-1:0] line_mem [MAX_WIDTH];   // {older, newer}
  win_t              window_q, window_d;

  always_comb begin
    if (width_q == '0) begin
      w_eff = SizeW'(1);
    end else if (SizeW'(width_q) > SizeW'(MAX_WIDTH)) begin
      w_eff = SizeW'(MAX_WIDTH);
    end else begin
      w_eff = SizeW'(width_q);
    end
    if (height_q == '0) begin
      h_eff = SizeW'(1);
    end else if (height_q > HeightRegW'(MaxHeight)) begin
      h_eff = SizeW'(MaxHeight);
    end else begin
      h_eff = SizeW'(height_q);
    end
    wlast    = CW'(w_eff - SizeW'(1));
    hlast    = RowW'(h_eff - SizeW'(1));
    c_cur    = (col_q > wlast) ? wlast : col_q;
    r_cur    = (row_q > hlast) ? hlast : row_q;
    end_cur  = (c_cur == wlast);
    last_cur = (r_cur == hlast);
  end

  assign pixel_i.ready = ((JobCntW + 1)'(q_count_i) + (JobCntW + 1)'(a_valid_q))
                         < (JobCntW + 1)'(JobDepth);
  assign acc           = pixel_i.valid && pixel_i.ready;
  assign cfg_i.ready   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthRegW'(WidthReset);
      height_q <= HeightRegW'(HeightReset);
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_IMAGE_WIDTH:  width_q  <= WidthRegW'(cfg_i.data);
        REG_IMAGE_HEIGHT: height_q <= HeightRegW'(cfg_i.data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= acc;
      if (acc) begin
        if (end_cur) begin
          col_q <= '0;
          row_q <= last_cur ? '0 : r_cur + RowW'(1);
        end else begin
          col_q <= c_cur + CW'(1);
          row_q <= r_cur;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      pix_a_q  <= pixel_i.pixel;
      c_a_q    <= c_cur;
      r_a_q    <= r_cur;
      end_a_q  <= end_cur;
      last_a_q <= last_cur;
    end
  end

  // line store: read on accept, write back in the cycle after, with bypass
  assign wr_data = {rd_q[PixW-1:0], pix_a_q};

  always_ff @(posedge clk_i) begin
    if (a_valid_q) begin
      line_mem[c_a_q] <= wr_data;
    end
    if (acc) begin
      if (a_valid_q && (c_a_q == c_cur)) begin
        rd_q <= wr_data;
      end else begin
        rd_q <= line_mem[c_cur];
      end
    end
  end

  assign window_d = {pix_a_q, rd_q[PixW-1:0], rd_q[2*PixW-1:PixW], window_q[8:3]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
    end else if (a_valid_q) begin
      window_q <= window_d;
    end
  end

  always_comb begin
    job_o.win     = window_d;
    job_o.row     = r_a_q;
    job_o.col     = ColW'(c_a_q);
    job_o.r_is0   = (r_a_q == '0);
    job_o.r_is1   = (r_a_q == RowW'(1));
    job_o.c_is0   = (c_a_q == '0);
    job_o.c_is1   = (c_a_q == CW'(1));
    job_o.mask[0] = !job_o.r_is0 && !job_o.c_is0;
    job_o.mask[1] = !job_o.r_is0 && end_a_q;
    job_o.mask[2] = last_a_q && !job_o.c_is0;
    job_o.mask[3] = last_a_q && end_a_q;
    push_o        = a_valid_q && (job_o.mask != '0);
  end

endmodule

// ===== rtl/core/ulbp_emit.sv =====
module ulbp_emit import ulbp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  job_t               head_i,
  input  logic [JobCntW-1:0] q_count_i,
  output logic               pop_o,
  ulbp_label_if.source       label_o
);

  logic [NumSlots-1:0] done_q, done_d;
  logic [NumSlots-1:0] remaining, sel_oh;
  logic [1:0]          slot;
  logic                head_valid, fire, mode, use_end;
  col_t                cols [3];
  col_t                lc, cc, rc;

  logic            ovalid_q;
  label_t          label_q, label_d;
  logic [RowW-1:0] orow_q, orow_d;
  logic [ColW-1:0] ocol_q, ocol_d;
  logic            fend_q, fend_d;

  always_comb begin
    head_valid = (q_count_i != '0);
    remaining  = head_i.mask & ~done_q;
    priority if (remaining[0]) begin
      slot = 2'd0;
    end else if (remaining[1]) begin
      slot = 2'd1;
    end else if (remaining[2]) begin
      slot = 2'd2;
    end else begin
      slot = 2'd3;
    end
    sel_oh  = NumSlots'(1) << slot;
    mode    = slot[1];
    use_end = slot[0];

    for (int k = 0; k < 3; k++) begin
      if (!mode) begin
        cols[k][0] = head_i.r_is1 ? head_i.win[3*k+1] : head_i.win[3*k];
        cols[k][1] = head_i.win[3*k+1];
        cols[k][2] = head_i.win[3*k+2];
      end else begin
        cols[k][0] = head_i.r_is0 ? head_i.win[3*k+2] : head_i.win[3*k+1];
        cols[k][1] = head_i.win[3*k+2];
        cols[k][2] = head_i.win[3*k+2];
      end
    end

    if (!use_end) begin
      lc     = head_i.c_is1 ? cols[1] : cols[0];
      cc     = cols[1];
      rc     = cols[2];
      ocol_d = head_i.col - ColW'(1);
    end else begin
      lc     = head_i.c_is0 ? cols[2] : cols[1];
      cc     = cols[2];
      rc     = cols[2];
      ocol_d = head_i.col;
    end
    label_d = lbp_label(lc, cc, rc);
    orow_d  = mode ? head_i.row : head_i.row - RowW'(1);
    fend_d  = (slot == 2'd3);

    fire  = head_valid && (!ovalid_q || label_o.ready);
    pop_o = fire && ((remaining & ~sel_oh) == '0);
    if (pop_o) begin
      done_d = '0;
    end else if (fire) begin
      done_d = done_q | sel_oh;
    end else begin
      done_d = done_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      done_q <= done_d;
      if (fire) begin
        ovalid_q <= 1'b1;
      end else if (label_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      label_q <= label_d;
      orow_q  <= orow_d;
      ocol_q  <= ocol_d;
      fend_q  <= fend_d;
    end
  end

  assign label_o.valid     = ovalid_q;
  assign label_o.label     = label_q;
  assign label_o.out_row   = orow_q;
  assign label_o.out_col   = ocol_q;
  assign label_o.frame_end = fend_q;

endmodule

// ===== rtl/core/uniform_lbp_pixel_stream_unit.sv =====
// channel   dir  payload                               accept
// pixel_i   in   pixel                                 valid && ready
// label_o   out  label, out_row, out_col, frame_end    valid && ready
// cfg_i     in   index (0 width, 1 height), data       valid && ready (ready always 1)
//
// One pixel per cycle while labels keep pace; a label passes the job queue and output register.
// Labels of row r-1 follow row r; the last row also emits its own labels, so
// an item yields up to four labels, one per cycle as label_o takes them, via a 4-deep queue.
// Row-end and last-row items give up to four labels, so the input stalls once the queue fills.
// pixel_i.ready drops while the job queue plus the line store read stage are full.
// Reset clears counters, window and queue; line store contents start undefined.
module uniform_lbp_pixel_stream_unit import ulbp_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MaxWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ulbp_pixel_if.sink  pixel_i,
  ulbp_label_if.source label_o,
  ulbp_cfg_if.sink    cfg_i
);

  logic               push, pop;
  job_t               job, head;
  logic [JobCntW-1:0] q_count;

  ulbp_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pixel_i   (pixel_i),
    .cfg_i     (cfg_i),
    .q_count_i (q_count),
    .push_o    (push),
    .job_o     (job)
  );

  ulbp_jobq u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job),
    .pop_i   (pop),
    .head_o  (head),
    .count_o (q_count)
  );

  ulbp_emit u_emit (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .head_i    (head),
    .q_count_i (q_count),
    .pop_o     (pop),
    .label_o   (label_o)
  );

endmodule

// ===== rtl/core/ulbp_checker.sv =====
`include "uniform_lbp_pixel_stream_unit_macros.svh"

module ulbp_checker import ulbp_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_ready_i,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input label_t          label_i,
  input logic [RowW-1:0] out_row_i,
  input logic [ColW-1:0] out_col_i,
  input logic            frame_end_i
);

  // label stays inside the uniform range
  `ULBP_ASSERT_IMP(a_label_range, clk_i, rst_ni, out_valid_i, label_i <= LabelW'(LabelMax))

  // stalled item holds
  `ULBP_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(label_i) && $stable(out_row_i) && $stable(out_col_i) && $stable(frame_end_i))

  // input held off on consecutive cycles means queued work is being presented
  `ULBP_ASSERT_IMP(a_no_starve, clk_i, rst_ni, !in_ready_i && $past(!in_ready_i), out_valid_i)

endmodule

bind uniform_lbp_pixel_stream_unit ulbp_checker u_ulbp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (pixel_i.ready),
  .out_valid_i (label_o.valid),
  .out_ready_i (label_o.ready),
  .label_i     (label_o.label),
  .out_row_i   (label_o.out_row),
  .out_col_i   (label_o.out_col),
  .frame_end_i (label_o.frame_end)
);
